FILE: design/met_pkg.sv
`default_nettype none
package met_pkg;

  localparam int unsigned MAX_COLUMNS   = 1024;
  localparam int unsigned MAX_ROWS      = 1024;
  localparam int unsigned FRACTION_BITS = 28;

  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned PROD_C_W = COORD_W + INDEX_W + 1;
  localparam int unsigned WIDE_W   = 2 * COORD_W;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd603979776;
  localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = -32'sd335544320;
  localparam logic signed [COORD_W-1:0] X_STEP_RST   = 32'sd6100806;
  localparam logic signed [COORD_W-1:0] Y_STEP_RST   = 32'sd20336019;
  localparam logic [COUNT_W-1:0]        LIMIT_RST    = 8'd64;

  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_LIMIT    = 3'd4
  } met_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_MUL,
    ST_C_ADD,
    ST_Z_SQR,
    ST_Z_UPD,
    ST_HOLD
  } met_state_e;

  typedef struct packed {
    logic load_in;
    logic mul_c;
    logic init_z;
    logic mul_z;
    logic step_z;
    logic load_out;
  } met_cmd_t;

  typedef struct packed {
    logic done;
  } met_status_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    lo = WIDE_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/mandelbrot_escape_time_unit.sv
`default_nettype none
// Escape-time unit for the Mandelbrot set: each input transaction carries a
// pixel column and row, the unit forms c = origin + index*step in signed Q4.28
// and iterates z = z*z + c until |z|^2 reaches 4 or the count hits
// iteration_limit, then returns one result transaction with the count and an
// inside flag. One pixel is in flight at a time. After acceptance the states
// C_MUL and C_ADD form c, then each iteration passes through Z_SQR (on the
// squaring multipliers) and Z_UPD (escape test and update), plus one final
// Z_SQR/Z_UPD pass that detects the exit; while the output register still
// holds an unaccepted result the unit waits in HOLD. Input is taken again
// once the result sits in the output register. The registers must be written
// over the APB port only while the unit is idle; the unit does not enforce this.
module mandelbrot_escape_time_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,   // column[9:0], row[19:10], zero pad
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // iteration_count[7:0]
  output logic [0:0]                        m_axis_tuser,   // inside_set[0]
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [met_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [met_pkg::DATA_W-1:0]   pwdata,
  output logic [met_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic signed [met_pkg::COORD_W-1:0] x_origin_q, y_origin_q, x_step_q, y_step_q;
  logic [met_pkg::COUNT_W-1:0] limit_q;
  logic wr_en;
  met_pkg::met_reg_e reg_sel;
  met_pkg::met_cmd_t cmd;
  met_pkg::met_status_t status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = met_pkg::met_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= met_pkg::X_ORIGIN_RST;
      y_origin_q <= met_pkg::Y_ORIGIN_RST;
      x_step_q   <= met_pkg::X_STEP_RST;
      y_step_q   <= met_pkg::Y_STEP_RST;
      limit_q    <= met_pkg::LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        met_pkg::REG_X_ORIGIN: x_origin_q <= $signed(pwdata);
        met_pkg::REG_Y_ORIGIN: y_origin_q <= $signed(pwdata);
        met_pkg::REG_X_STEP:   x_step_q   <= $signed(pwdata);
        met_pkg::REG_Y_STEP:   y_step_q   <= $signed(pwdata);
        met_pkg::REG_LIMIT:    limit_q    <= pwdata[met_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      met_pkg::REG_X_ORIGIN: prdata = x_origin_q;
      met_pkg::REG_Y_ORIGIN: prdata = y_origin_q;
      met_pkg::REG_X_STEP:   prdata = x_step_q;
      met_pkg::REG_Y_STEP:   prdata = y_step_q;
      met_pkg::REG_LIMIT:    prdata = met_pkg::DATA_W'(limit_q);
      default:               prdata = '0;
    endcase
  end

  met_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  met_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .column_i   (s_axis_tdata[9:0]),
    .row_i      (s_axis_tdata[19:10]),
    .x_origin_i (x_origin_q),
    .y_origin_i (y_origin_q),
    .x_step_i   (x_step_q),
    .y_step_i   (y_step_q),
    .limit_i    (limit_q),
    .count_o    (m_axis_tdata),
    .inside_o   (m_axis_tuser[0])
  );

  a_inside_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == limit_q))
    else $error("inside result with count not at limit");

  a_outside_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata < limit_q))
    else $error("escaped result with count at or above limit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a pixel is in flight");

endmodule
`default_nettype wire

FILE: design/met_ctrl.sv
`default_nettype none
module met_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire met_pkg::met_status_t  status_i,
  output met_pkg::met_cmd_t          cmd_o
);

  met_pkg::met_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      met_pkg::ST_IDLE:  if (in_valid_i) state_d = met_pkg::ST_C_MUL;
      met_pkg::ST_C_MUL: state_d = met_pkg::ST_C_ADD;
      met_pkg::ST_C_ADD: state_d = met_pkg::ST_Z_SQR;
      met_pkg::ST_Z_SQR: state_d = met_pkg::ST_Z_UPD;
      met_pkg::ST_Z_UPD: begin
        if (!status_i.done) begin
          state_d = met_pkg::ST_Z_SQR;
        end else if (out_free) begin
          state_d = met_pkg::ST_IDLE;
        end else begin
          state_d = met_pkg::ST_HOLD;
        end
      end
      met_pkg::ST_HOLD:  if (out_free) state_d = met_pkg::ST_IDLE;
      default:           state_d = met_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == met_pkg::ST_IDLE) && in_valid_i;
    cmd_o.mul_c    = (state_q == met_pkg::ST_C_MUL);
    cmd_o.init_z   = (state_q == met_pkg::ST_C_ADD);
    cmd_o.mul_z    = (state_q == met_pkg::ST_Z_SQR);
    cmd_o.step_z   = (state_q == met_pkg::ST_Z_UPD) && !status_i.done;
    cmd_o.load_out = (((state_q == met_pkg::ST_Z_UPD) && status_i.done) ||
                      (state_q == met_pkg::ST_HOLD)) && out_free;
    in_ready_o     = (state_q == met_pkg::ST_IDLE);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= met_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/met_dp.sv
`default_nettype none
module met_dp (
  input  wire logic                                      clk_i,
  input  wire met_pkg::met_cmd_t                         cmd_i,
  output met_pkg::met_status_t                           status_o,
  input  wire logic [met_pkg::INDEX_W-1:0]               column_i,
  input  wire logic [met_pkg::INDEX_W-1:0]               row_i,
  input  wire logic signed [met_pkg::COORD_W-1:0]        x_origin_i,
  input  wire logic signed [met_pkg::COORD_W-1:0]        y_origin_i,
  input  wire logic signed [met_pkg::COORD_W-1:0]        x_step_i,
  input  wire logic signed [met_pkg::COORD_W-1:0]        y_step_i,
  input  wire logic [met_pkg::COUNT_W-1:0]               limit_i,
  output logic [met_pkg::COUNT_W-1:0]                    count_o,
  output logic                                           inside_o
);

  localparam int unsigned Iw = met_pkg::INDEX_W;
  localparam int unsigned Cw = met_pkg::COORD_W;
  localparam int unsigned Pw = met_pkg::PROD_C_W;
  localparam int unsigned Ww = met_pkg::WIDE_W;
  localparam int unsigned Fb = met_pkg::FRACTION_BITS;
  localparam logic [Ww-1:0] Four = Ww'(1) << (2 * Fb + 2);

  logic [Iw-1:0] col_q, row_q;
  logic [Iw-1:0] col_d, row_d;
  logic signed [Pw-1:0] prod_x_q, prod_y_q;
  logic signed [Cw-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [Cw-1:0] zr_d, zi_d;
  logic signed [Ww-1:0] rr_q, ii_q, ri_q;
  logic signed [Ww-1:0] diff;
  logic [Ww-1:0] mag;
  logic [met_pkg::COUNT_W-1:0] count_q;
  logic [met_pkg::COUNT_W-1:0] count_out_q;
  logic inside_out_q;

  always_comb begin
    col_d = (32'(column_i) >= met_pkg::MAX_COLUMNS) ? Iw'(met_pkg::MAX_COLUMNS - 1) : column_i;
    row_d = (32'(row_i) >= met_pkg::MAX_ROWS) ? Iw'(met_pkg::MAX_ROWS - 1) : row_i;
  end

  always_comb begin
    mag  = $unsigned(rr_q) + $unsigned(ii_q);
    diff = rr_q - ii_q;
    zr_d = met_pkg::sat32((diff >>> Fb) + Ww'(cr_q));
    zi_d = met_pkg::sat32((ri_q >>> (Fb - 1)) + Ww'(ci_q));
    status_o.done = (count_q >= limit_i) || (mag >= Four);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      col_q <= col_d;
      row_q <= row_d;
    end
    if (cmd_i.mul_c) begin
      prod_x_q <= Pw'($signed({1'b0, col_q})) * Pw'(x_step_i);
      prod_y_q <= Pw'($signed({1'b0, row_q})) * Pw'(y_step_i);
    end
    if (cmd_i.init_z) begin
      cr_q    <= met_pkg::sat32(Ww'(x_origin_i) + Ww'(prod_x_q));
      ci_q    <= met_pkg::sat32(Ww'(y_origin_i) + Ww'(prod_y_q));
      zr_q    <= '0;
      zi_q    <= '0;
      count_q <= '0;
    end
    if (cmd_i.mul_z) begin
      rr_q <= Ww'(zr_q) * Ww'(zr_q);
      ii_q <= Ww'(zi_q) * Ww'(zi_q);
      ri_q <= Ww'(zr_q) * Ww'(zi_q);
    end
    if (cmd_i.step_z) begin
      zr_q    <= zr_d;
      zi_q    <= zi_d;
      count_q <= count_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      count_out_q  <= count_q;
      inside_out_q <= (count_q == limit_i);
    end
  end

  assign count_o  = count_out_q;
  assign inside_o = inside_out_q;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int unsigned LONG_HOLD   = 800;

  localparam logic signed [31:0] DEF_X_ORIGIN = -32'sd603979776;
  localparam logic signed [31:0] DEF_Y_ORIGIN = -32'sd335544320;
  localparam logic signed [31:0] DEF_X_STEP   = 32'sd6100806;
  localparam logic signed [31:0] DEF_Y_STEP   = 32'sd20336019;
  localparam logic [7:0]         DEF_LIMIT    = 8'd64;

  typedef struct packed {
    logic [7:0] count;
    logic       in_set;
  } escape_result_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_MASK
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // column[9:0], row[19:10], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // iteration_count[7:0]
  logic [0:0]  m_axis_tuser;         // inside_set[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [met_pkg::ADDR_W-1:0] paddr = '0;
  logic [met_pkg::DATA_W-1:0] pwdata = '0;
  logic [met_pkg::DATA_W-1:0] prdata;
  logic        pready;

  logic signed [31:0] cfg_x_origin = DEF_X_ORIGIN;
  logic signed [31:0] cfg_y_origin = DEF_Y_ORIGIN;
  logic signed [31:0] cfg_x_step   = DEF_X_STEP;
  logic signed [31:0] cfg_y_step   = DEF_Y_STEP;
  logic [7:0]         cfg_limit    = DEF_LIMIT;

  escape_result_t escape_results_q[$];
  int unsigned    mismatch_count = 0;
  int unsigned    burst_left = 0;

  rx_mode_e    rx_mode = RX_STREAM;
  int unsigned rx_mode_left = 0;
  logic [7:0]  rx_mask = 8'hFF;
  logic        hold_token = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  mandelbrot_escape_time_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_coord(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic escape_result_t predict_escape(input logic [9:0] col,
                                                    input logic [9:0] row);
    longint          cr, ci, zr, zi, rr, ii, ri;
    longint unsigned escape_bound;
    int unsigned     n;
    escape_result_t  r;
    escape_bound = 64'd1 << (2 * met_pkg::FRACTION_BITS + 2);
    cr = clamp_coord(longint'(cfg_x_origin) + longint'(col) * longint'(cfg_x_step));
    ci = clamp_coord(longint'(cfg_y_origin) + longint'(row) * longint'(cfg_y_step));
    zr = 0;
    zi = 0;
    n = 0;
    while (n < cfg_limit) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      if ($unsigned(rr) + $unsigned(ii) >= escape_bound) break;
      zr = clamp_coord(((rr - ii) >>> met_pkg::FRACTION_BITS) + cr);
      zi = clamp_coord((ri >>> (met_pkg::FRACTION_BITS - 1)) + ci);
      n++;
    end
    r.count = n[7:0];
    r.in_set = (n == cfg_limit);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    escape_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (escape_results_q.size() == 0) begin
        report_mismatch("result transaction with none pending", 32'(m_axis_tdata), 32'd0);
      end else begin
        want = escape_results_q.pop_front();
        if (m_axis_tdata !== want.count) begin
          report_mismatch("iteration_count", 32'(m_axis_tdata), 32'(want.count));
        end
        if (m_axis_tuser[0] !== want.in_set) begin
          report_mismatch("inside_set", 32'(m_axis_tuser[0]), 32'(want.in_set));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(16, 200);
        rx_mask <= 8'($urandom);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STREAM: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default:   m_axis_tready <= rx_mask[rx_mode_left[2:0]];
      endcase
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (index)
      met_pkg::REG_X_ORIGIN: cfg_x_origin = value;
      met_pkg::REG_Y_ORIGIN: cfg_y_origin = value;
      met_pkg::REG_X_STEP:   cfg_x_step = value;
      met_pkg::REG_Y_STEP:   cfg_y_step = value;
      met_pkg::REG_LIMIT:    cfg_limit = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [31:0] x_origin, input logic [31:0] y_origin,
                          input logic [31:0] x_step, input logic [31:0] y_step,
                          input logic [7:0] limit);
    write_register(met_pkg::REG_X_ORIGIN, x_origin);
    write_register(met_pkg::REG_Y_ORIGIN, y_origin);
    write_register(met_pkg::REG_X_STEP, x_step);
    write_register(met_pkg::REG_Y_STEP, y_step);
    write_register(met_pkg::REG_LIMIT, {24'd0, limit});
  endtask

  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    escape_result_t want;
    want = predict_escape(col, row);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    escape_results_q.push_back(want);
    burst_left--;
  endtask

  task automatic send_random_pixels(input int unsigned count);
    repeat (count) send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (escape_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_reset_view();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd99, 10'd16);
    send_pixel(10'd66, 10'd16);
    send_pixel(10'd132, 10'd16);
    send_random_pixels(600);
    wait_idle();
  endtask

  task automatic test_iteration_limits();
    write_register(met_pkg::REG_LIMIT, 32'd0);
    send_pixel(10'd99, 10'd16);
    send_pixel(10'd0, 10'd0);
    wait_idle();
    write_register(met_pkg::REG_LIMIT, 32'd1);
    send_pixel(10'd99, 10'd16);
    send_pixel(10'd0, 10'd0);
    wait_idle();
    write_register(met_pkg::REG_LIMIT, 32'd255);
    send_pixel(10'd99, 10'd16);
    send_pixel(10'd66, 10'd17);
    wait_idle();
  endtask

  task automatic test_coordinate_saturation();
    set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd8);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    wait_idle();
    set_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd8);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1);
    wait_idle();
    set_view(32'd0, 32'd0, 32'd0, 32'd0, 8'd200);
    send_pixel(10'd1023, 10'd1023);
    wait_idle();
  endtask

  task automatic test_register_index_past_end();
    set_view(DEF_X_ORIGIN, DEF_Y_ORIGIN, DEF_X_STEP, DEF_Y_STEP, DEF_LIMIT);
    for (int i = met_pkg::REG_LIMIT + 1; i < (1 << $bits(met_pkg::met_reg_e)); i++) begin
      write_register(i[2:0], $urandom);
    end
    send_pixel(10'd99, 10'd16);
    send_pixel(10'd0, 10'd0);
    wait_idle();
  endtask

  task automatic test_random_views();
    int xs, ys;
    repeat (6) begin
      xs = $urandom_range(64, 1 << 20);
      ys = $urandom_range(64, 1 << 20);
      if ($urandom_range(0, 3) == 0) xs = -xs;
      if ($urandom_range(0, 3) == 0) ys = -ys;
      set_view($urandom_range(0, 939524096) - 671088640,
               $urandom_range(0, 805306368) - 402653184,
               xs, ys, 8'($urandom_range(1, 160)));
      send_random_pixels(150);
      wait_idle();
    end
  endtask

  task automatic test_random_registers();
    repeat (3) begin
      set_view($urandom, $urandom, $urandom, $urandom, 8'($urandom_range(0, 255)));
      send_random_pixels(50);
      wait_idle();
    end
  endtask

  task automatic test_deep_iterations();
    set_view(-32'sd214748365, -32'sd13421773, 32'sd26240, 32'sd26240, 8'd255);
    send_random_pixels(120);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    set_view(DEF_X_ORIGIN, DEF_Y_ORIGIN, DEF_X_STEP, DEF_Y_STEP, 8'd32);
    hold_token <= ~hold_token;
    send_random_pixels(40);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_view();
    test_iteration_limits();
    test_coordinate_saturation();
    test_register_index_past_end();
    test_random_views();
    test_random_registers();
    test_deep_iterations();
    test_output_backpressure();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
